### rtl/bpl_pkg.sv
// shared types, constants and the cordic arctangent table for the loss factor block
package bpl_pkg;

  localparam int ANG_FULL  = 23040;
  localparam int ANG_HALF  = 11520;
  localparam int ANG_RIGHT = 5760;
  localparam int GAIN_Q30  = 652032874;
  localparam int ONE_Q30   = 1073741824;

  // classified item handed from the front to the back
  typedef struct packed {
    logic [2:0]         channel;
    logic               neg;
    logic signed [13:0] ang;
    logic [31:0]        vmag;
    logic [31:0]        imag;
  } bpl_item_t;

  // one finished result
  typedef struct packed {
    logic [2:0]         channel_out;
    logic signed [15:0] power_factor;
    logic signed [31:0] loss_factor;
    logic signed [32:0] resistive_current;
    logic [32:0]        capacitive_current;
    logic [31:0]        reactance;
    logic               divide_error;
    logic               loss_saturated;
  } bpl_result_t;

  // arctangent of 2^-i, 1/64 degree scaled by 65536
  function automatic logic signed [31:0] cordic_atan(input int idx);
    logic signed [31:0] v;
    case (idx)
      0:  v = 32'sd188743680;
      1:  v = 32'sd111421900;
      2:  v = 32'sd58872272;
      3:  v = 32'sd29884485;
      4:  v = 32'sd15000234;
      5:  v = 32'sd7507429;
      6:  v = 32'sd3754631;
      7:  v = 32'sd1877430;
      8:  v = 32'sd938729;
      9:  v = 32'sd469366;
      10: v = 32'sd234683;
      11: v = 32'sd117342;
      12: v = 32'sd58671;
      13: v = 32'sd29335;
      14: v = 32'sd14668;
      15: v = 32'sd7334;
      16: v = 32'sd3667;
      17: v = 32'sd1833;
      18: v = 32'sd917;
      19: v = 32'sd458;
      20: v = 32'sd229;
      21: v = 32'sd115;
      22: v = 32'sd57;
      23: v = 32'sd29;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/bushing_phasor_loss_factor_top.sv
// top level of the bushing phasor power factor and loss factor block
// One transaction in carries a channel's voltage and current phasor; one transaction out
// carries power factor cos(theta) in Q2.14, loss factor cot(theta) in Q16.16, resistive and
// capacitive current and the reactance V/Ic, for theta = voltage angle minus current angle.
// The block takes one transaction per clock for as long as results are popped. An accepted
// transaction is written into the hand-off queue, then passes one register per cordic
// rotation, three of post-processing, thirty-two divider stages (one quotient bit per stage)
// and is written into the output queue. When the output queue fills, the whole back pipeline
// holds, and then the hand-off queue fills and raises in_full.
module bushing_phasor_loss_factor_top #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int QUEUE_DEPTH       = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transactions
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_channel,
  input  logic signed [14:0] in_voltage_angle,
  input  logic signed [14:0] in_current_angle,
  input  logic [31:0]        in_voltage_magnitude,
  input  logic [31:0]        in_current_magnitude,
  // result transactions
  output logic               out_empty,
  input  logic               out_pop,
  output logic [2:0]         out_channel_out,
  output logic signed [15:0] out_power_factor,
  output logic signed [31:0] out_loss_factor,
  output logic signed [32:0] out_resistive_current,
  output logic [32:0]        out_capacitive_current,
  output logic [31:0]        out_reactance,
  output logic               out_divide_error,
  output logic               out_loss_saturated
);
  import bpl_pkg::*;

  bpl_item_t   q_item;
  logic        q_valid, q_pop;
  bpl_result_t res, res_q;
  logic        res_valid, res_full;

  // front: angle difference reduced and folded, then queued
  bpl_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (in_push),
    .full              (in_full),
    .channel           (in_channel),
    .voltage_angle     (in_voltage_angle),
    .current_angle     (in_current_angle),
    .voltage_magnitude (in_voltage_magnitude),
    .current_magnitude (in_current_magnitude),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop)
  );

  // back: cordic, products and quotients in a stallable pipeline
  bpl_back #(
    .ITER (CORDIC_ITERATIONS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_full  (res_full)
  );

  // output queue parts the pipeline from the consumer
  bpl_fifo #(
    .WIDTH ($bits(bpl_result_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_q),
    .empty (out_empty)
  );

  assign out_channel_out        = res_q.channel_out;
  assign out_power_factor       = res_q.power_factor;
  assign out_loss_factor        = res_q.loss_factor;
  assign out_resistive_current  = res_q.resistive_current;
  assign out_capacitive_current = res_q.capacitive_current;
  assign out_reactance          = res_q.reactance;
  assign out_divide_error       = res_q.divide_error;
  assign out_loss_saturated     = res_q.loss_saturated;

endmodule

### rtl/bpl_fifo.sv
// small register queue with push/full and pop/empty sides
module bpl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             wr, rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (rd) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

### rtl/bpl_front.sv
// front end: angle difference, wrap and quadrant fold, then the hand-off queue
module bpl_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [2:0]            channel,
  input  logic signed [14:0]    voltage_angle,
  input  logic signed [14:0]    current_angle,
  input  logic [31:0]           voltage_magnitude,
  input  logic [31:0]           current_magnitude,
  output logic                  q_valid,
  output bpl_pkg::bpl_item_t    q_item,
  input  logic                  q_pop
);
  import bpl_pkg::*;

  logic signed [16:0] diff, wrapped;
  bpl_item_t          item;
  logic               q_empty;

  always_comb begin
    diff = 17'(voltage_angle) - 17'(current_angle);
    // bring into [-180, 180)
    if (diff >= 17'sd11520) begin
      wrapped = diff - 17'(ANG_FULL);
    end else if (diff < -17'sd11520) begin
      wrapped = diff + 17'(ANG_FULL);
    end else begin
      wrapped = diff;
    end
    item.channel = channel;
    item.vmag    = voltage_magnitude;
    item.imag    = current_magnitude;
    // fold the outer quadrants by half a turn
    if (wrapped > 17'(ANG_RIGHT)) begin
      item.neg = 1'b1;
      item.ang = 14'(wrapped - 17'(ANG_HALF));
    end else if (wrapped < -17'(ANG_RIGHT)) begin
      item.neg = 1'b1;
      item.ang = 14'(wrapped + 17'(ANG_HALF));
    end else begin
      item.neg = 1'b0;
      item.ang = 14'(wrapped);
    end
  end

  bpl_fifo #(
    .WIDTH ($bits(bpl_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (item),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  assign q_valid = !q_empty;

endmodule

### rtl/bpl_back.sv
// back end: pipelined cordic, post-processing, multiply and two pipelined dividers
module bpl_back #(
  parameter int ITER = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  bpl_pkg::bpl_item_t    q_item,
  output logic                  q_pop,
  output logic                  res_valid,
  output bpl_pkg::bpl_result_t  res,
  input  logic                  res_full
);
  import bpl_pkg::*;

  localparam int XW = 34;
  localparam int DS = 32;

  typedef struct packed {
    logic [2:0]  channel;
    logic        neg;
    logic [31:0] vmag;
    logic [31:0] imag;
  } meta_t;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [15:0] pf;
    logic signed [32:0] ir;
    logic [32:0]        ic;
    logic               cneg;
    logic               szero;
    logic               qneg;
    logic               lovf;
    logic [30:0]        ldiv;
    logic [30:0]        lrem;
    logic [31:0]        lfeed;
    logic [31:0]        lq;
    logic               icz;
    logic               rovf;
    logic [32:0]        rrem;
    logic [31:0]        rfeed;
    logic [31:0]        rq;
  } div_t;

  function automatic logic signed [31:0] clamp_one(input logic signed [XW-1:0] v);
    logic signed [31:0] r;
    if (v > XW'(ONE_Q30)) begin
      r = 32'(ONE_Q30);
    end else if (v < -XW'(ONE_Q30)) begin
      r = -32'(ONE_Q30);
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  logic en;

  // ---------------- cordic stages
  logic signed [XW-1:0] cx_r [ITER];
  logic signed [XW-1:0] cy_r [ITER];
  logic signed [31:0]   cz_r [ITER];
  meta_t                cm_r [ITER];
  logic                 cv_r [ITER];

  for (genvar k = 0; k < ITER; k++) begin : g_cordic
    logic signed [XW-1:0] px, py, xs, ys;
    logic signed [31:0]   pz;
    meta_t                pm;
    logic                 pv;
    if (k == 0) begin : g_first
      assign px = XW'(GAIN_Q30);
      assign py = '0;
      assign pz = 32'(q_item.ang) <<< 16;
      assign pm = '{channel: q_item.channel, neg: q_item.neg,
                    vmag: q_item.vmag, imag: q_item.imag};
      assign pv = q_valid;
    end else begin : g_next
      assign px = cx_r[k-1];
      assign py = cy_r[k-1];
      assign pz = cz_r[k-1];
      assign pm = cm_r[k-1];
      assign pv = cv_r[k-1];
    end
    assign xs = px >>> k;
    assign ys = py >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k] <= 1'b0;
      end else if (en) begin
        cv_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cm_r[k] <= pm;
        if (!pz[31]) begin
          cx_r[k] <= px - ys;
          cy_r[k] <= py + xs;
          cz_r[k] <= pz - cordic_atan(k);
        end else begin
          cx_r[k] <= px + ys;
          cy_r[k] <= py - xs;
          cz_r[k] <= pz + cordic_atan(k);
        end
      end
    end
  end

  // ---------------- p1: unfold, clamp, power factor
  logic signed [XW-1:0] nx, ny;
  logic signed [31:0]   cc, ss;
  logic signed [32:0]   pfsum, pfsh;
  logic signed [15:0]   pf;
  logic signed [31:0]   p1_c_r, p1_s_r;
  logic signed [15:0]   p1_pf_r;
  meta_t                p1_m_r;
  logic                 p1_v_r;

  always_comb begin
    nx    = cm_r[ITER-1].neg ? -cx_r[ITER-1] : cx_r[ITER-1];
    ny    = cm_r[ITER-1].neg ? -cy_r[ITER-1] : cy_r[ITER-1];
    cc    = clamp_one(nx);
    ss    = clamp_one(ny);
    pfsum = 33'(cc) + 33'sd32768;
    pfsh  = pfsum >>> 16;
    if (pfsh > 33'sd16384) begin
      pf = 16'sd16384;
    end else if (pfsh < -33'sd16384) begin
      pf = -16'sd16384;
    end else begin
      pf = 16'(pfsh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= cv_r[ITER-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_c_r  <= cc;
      p1_s_r  <= ss;
      p1_pf_r <= pf;
      p1_m_r  <= cm_r[ITER-1];
    end
  end

  // ---------------- p2: magnitudes, overflow test, current product
  logic [30:0]        ac, as;
  logic [14:0]        apf;
  logic [30:0]        p2_ac_r, p2_as_r;
  logic               p2_cneg_r, p2_qneg_r, p2_szero_r, p2_lovf_r, p2_pfneg_r;
  logic signed [15:0] p2_pf_r;
  logic [46:0]        p2_prod_r;
  meta_t              p2_m_r;
  logic               p2_v_r;

  always_comb begin
    ac  = p1_c_r[31] ? 31'(-p1_c_r) : 31'(p1_c_r);
    as  = p1_s_r[31] ? 31'(-p1_s_r) : 31'(p1_s_r);
    apf = p1_pf_r[15] ? 15'(-p1_pf_r) : 15'(p1_pf_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_ac_r    <= ac;
      p2_as_r    <= as;
      p2_cneg_r  <= p1_c_r[31];
      p2_qneg_r  <= p1_c_r[31] ^ p1_s_r[31];
      p2_szero_r <= (p1_s_r == '0);
      p2_lovf_r  <= (31'(ac[30:16]) >= as);
      p2_pfneg_r <= p1_pf_r[15];
      p2_pf_r    <= p1_pf_r;
      p2_prod_r  <= 47'(apf) * 47'(p1_m_r.imag);
      p2_m_r     <= p1_m_r;
    end
  end

  // ---------------- p3: resistive and capacitive current, divider set-up
  logic [46:0]        rsum;
  logic [31:0]        irm;
  logic signed [32:0] ir;
  logic [32:0]        ic;
  div_t               dinit;

  always_comb begin
    rsum = p2_prod_r + 47'd8192;
    irm  = rsum[45:14];
    ir   = p2_pfneg_r ? -$signed({1'b0, irm}) : $signed({1'b0, irm});
    ic   = {1'b0, p2_m_r.imag} - 33'(ir);
    dinit.channel = p2_m_r.channel;
    dinit.pf      = p2_pf_r;
    dinit.ir      = ir;
    dinit.ic      = ic;
    dinit.cneg    = p2_cneg_r;
    dinit.szero   = p2_szero_r;
    dinit.qneg    = p2_qneg_r;
    dinit.lovf    = p2_lovf_r;
    dinit.ldiv    = p2_as_r;
    dinit.lrem    = 31'(p2_ac_r[30:16]);
    dinit.lfeed   = {p2_ac_r[15:0], 16'd0};
    dinit.lq      = '0;
    dinit.icz     = (ic == '0);
    dinit.rovf    = (33'(p2_m_r.vmag[31:16]) >= ic);
    dinit.rrem    = 33'(p2_m_r.vmag[31:16]);
    dinit.rfeed   = {p2_m_r.vmag[15:0], 16'd0};
    dinit.rq      = '0;
  end

  div_t p3_r;
  logic p3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r <= dinit;
    end
  end

  // ---------------- divider stages, one quotient bit of each per stage
  div_t dv_r [DS];
  logic dvv_r [DS];

  for (genvar k = 0; k < DS; k++) begin : g_div
    div_t       pd, nd;
    logic       pv;
    logic [31:0] lt;
    logic [33:0] rt;
    if (k == 0) begin : g_first
      assign pd = p3_r;
      assign pv = p3_v_r;
    end else begin : g_next
      assign pd = dv_r[k-1];
      assign pv = dvv_r[k-1];
    end

    always_comb begin
      nd    = pd;
      lt    = {pd.lrem, pd.lfeed[31]};
      rt    = {pd.rrem, pd.rfeed[31]};
      nd.lfeed = {pd.lfeed[30:0], 1'b0};
      nd.rfeed = {pd.rfeed[30:0], 1'b0};
      if (lt >= 32'(pd.ldiv)) begin
        nd.lrem = 31'(lt - 32'(pd.ldiv));
        nd.lq   = {pd.lq[30:0], 1'b1};
      end else begin
        nd.lrem = lt[30:0];
        nd.lq   = {pd.lq[30:0], 1'b0};
      end
      if (rt >= 34'(pd.ic)) begin
        nd.rrem = 33'(rt - 34'(pd.ic));
        nd.rq   = {pd.rq[30:0], 1'b1};
      end else begin
        nd.rrem = rt[32:0];
        nd.rq   = {pd.rq[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[k] <= 1'b0;
      end else if (en) begin
        dvv_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k] <= nd;
      end
    end
  end

  // ---------------- saturation and result packing
  div_t fd;

  always_comb begin
    fd = dv_r[DS-1];
    res.channel_out        = fd.channel;
    res.power_factor       = fd.pf;
    res.resistive_current  = fd.ir;
    res.capacitive_current = fd.ic;
    if (fd.szero) begin
      res.loss_factor    = fd.cneg ? 32'sh80000000 : 32'sh7fffffff;
      res.loss_saturated = 1'b1;
    end else if (!fd.qneg) begin
      if (fd.lovf || fd.lq > 32'h7fffffff) begin
        res.loss_factor    = 32'sh7fffffff;
        res.loss_saturated = 1'b1;
      end else begin
        res.loss_factor    = $signed(fd.lq);
        res.loss_saturated = 1'b0;
      end
    end else begin
      if (fd.lovf || fd.lq > 32'h80000000) begin
        res.loss_factor    = 32'sh80000000;
        res.loss_saturated = 1'b1;
      end else begin
        res.loss_factor    = -$signed(fd.lq);
        res.loss_saturated = 1'b0;
      end
    end
    if (fd.icz || fd.rovf) begin
      res.reactance    = 32'hffffffff;
      res.divide_error = 1'b1;
    end else begin
      res.reactance    = fd.rq;
      res.divide_error = 1'b0;
    end
  end

  assign res_valid = dvv_r[DS-1];
  assign en        = !(res_valid && res_full);
  assign q_pop     = en && q_valid;

endmodule

### rtl/bpl_chk.sv
// port-level checker for the loss factor block, bound to the top level
module bpl_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic [2:0]         out_channel_out,
  input logic signed [15:0] out_power_factor,
  input logic signed [31:0] out_loss_factor,
  input logic [31:0]        out_reactance,
  input logic               out_divide_error,
  input logic               out_loss_saturated
);

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !out_empty && !out_pop) |=> (!out_empty && $stable(out_channel_out)
      && $stable(out_loss_factor) && $stable(out_reactance)))
    else $error("waiting result changed");

  a_loss_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_loss_saturated) |->
      (out_loss_factor == 32'sh7fffffff || out_loss_factor == 32'sh80000000))
    else $error("saturated loss factor not at a limit");

  a_div_err: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_divide_error) |-> (out_reactance == 32'hffffffff))
    else $error("divide error without saturated reactance");

  a_pf_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_power_factor <= 16'sd16384 && out_power_factor >= -16'sd16384))
    else $error("power factor out of range");

endmodule

bind bushing_phasor_loss_factor_top bpl_chk u_chk (.*);

### dv/tb_bushing_phasor_loss_factor_top.sv
// testbench for the bushing phasor power factor and loss factor block
`timescale 1ns / 100ps

module tb_bushing_phasor_loss_factor_top;
  import bpl_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int DRAIN_CYCLES = CORDIC_STEPS + 60;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1300;

  // one expected result, in the block's own widths
  typedef struct {
    logic [2:0]         channel_out;
    logic signed [15:0] power_factor;
    logic signed [31:0] loss_factor;
    logic signed [32:0] resistive_current;
    logic [32:0]        capacitive_current;
    logic [31:0]        reactance;
    logic               divide_error;
    logic               loss_saturated;
  } phasor_result_t;

  // arctangent of 2^-i in 1/64 degree scaled by 65536
  localparam longint ATAN_STEP [24] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

  // works out power factor, loss factor, currents and reactance of one phasor pair
  function automatic phasor_result_t compute_loss_factor(
      logic [2:0] chan, logic signed [14:0] va, logic signed [14:0] ia,
      logic [31:0] vm, logic [31:0] im);
    phasor_result_t r;
    longint theta, x, y, z, xs, ys, cosv, sinv, pf, lf, ir, ic_s;
    longint unsigned acos_v, asin_v, quot, apf, irm, react;
    bit flip, qneg;
    theta = longint'(va) - longint'(ia);
    theta = ((theta % ANG_FULL) + ANG_FULL) % ANG_FULL;
    if (theta >= ANG_HALF) theta -= ANG_FULL;
    flip = 0;
    if (theta > ANG_RIGHT) begin
      theta -= ANG_HALF; flip = 1;
    end else if (theta < -ANG_RIGHT) begin
      theta += ANG_HALF; flip = 1;
    end
    z = theta * 65536;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_STEP[i];
      end else begin
        x += ys; y -= xs; z += ATAN_STEP[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cosv = (x > ONE_Q30) ? ONE_Q30 : (x < -ONE_Q30) ? -ONE_Q30 : x;
    sinv = (y > ONE_Q30) ? ONE_Q30 : (y < -ONE_Q30) ? -ONE_Q30 : y;
    pf = (cosv + 32768) >>> 16;
    if (pf > 16384) pf = 16384;
    if (pf < -16384) pf = -16384;
    r.loss_saturated = 0;
    if (sinv == 0) begin
      lf = (cosv >= 0) ? 64'sd2147483647 : -64'sd2147483648;
      r.loss_saturated = 1;
    end else begin
      acos_v = (cosv < 0) ? -cosv : cosv;
      asin_v = (sinv < 0) ? -sinv : sinv;
      quot = (acos_v << 16) / asin_v;
      qneg = (cosv < 0) != (sinv < 0);
      if (!qneg) begin
        if (quot > 64'd2147483647) begin
          quot = 64'd2147483647; r.loss_saturated = 1;
        end
        lf = quot;
      end else begin
        if (quot > 64'd2147483648) begin
          quot = 64'd2147483648; r.loss_saturated = 1;
        end
        lf = -longint'(quot);
      end
    end
    apf = (pf < 0) ? -pf : pf;
    irm = (apf * im + 8192) >> 14;
    ir = (pf < 0) ? -longint'(irm) : longint'(irm);
    ic_s = longint'(im) - ir;
    r.divide_error = 0;
    if (ic_s == 0) begin
      react = 64'hFFFF_FFFF; r.divide_error = 1;
    end else begin
      react = (longint'(vm) << 16) / longint'(ic_s);
      if (react > 64'hFFFF_FFFF) begin
        react = 64'hFFFF_FFFF; r.divide_error = 1;
      end
    end
    r.channel_out        = chan;
    r.power_factor       = pf[15:0];
    r.loss_factor        = lf[31:0];
    r.resistive_current  = ir[32:0];
    r.capacitive_current = ic_s[32:0];
    r.reactance          = react[31:0];
    return r;
  endfunction

  // holds expected phasor results in order and compares each popped one
  class phasor_scoreboard;
    phasor_result_t pending[$];
    int errors = 0;

    function void note_phasor(logic [2:0] c, logic signed [14:0] va, logic signed [14:0] ia,
                              logic [31:0] vm, logic [31:0] im);
      pending.push_back(compute_loss_factor(c, va, ia, vm, im));
    endfunction

    function void check_result(phasor_result_t got);
      phasor_result_t w;
      if (pending.size() == 0) begin
        $error("result with nothing expected, channel %0d", got.channel_out);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.channel_out !== w.channel_out) begin
        $error("channel_out exp %0d got %0d", w.channel_out, got.channel_out); errors++;
      end
      if (got.power_factor !== w.power_factor) begin
        $error("power_factor exp %0d got %0d", w.power_factor, got.power_factor); errors++;
      end
      if (got.loss_factor !== w.loss_factor) begin
        $error("loss_factor exp %0d got %0d", w.loss_factor, got.loss_factor); errors++;
      end
      if (got.resistive_current !== w.resistive_current) begin
        $error("resistive_current exp %0d got %0d", w.resistive_current,
               got.resistive_current); errors++;
      end
      if (got.capacitive_current !== w.capacitive_current) begin
        $error("capacitive_current exp %0d got %0d", w.capacitive_current,
               got.capacitive_current); errors++;
      end
      if (got.reactance !== w.reactance) begin
        $error("reactance exp %0h got %0h", w.reactance, got.reactance); errors++;
      end
      if (got.divide_error !== w.divide_error) begin
        $error("divide_error exp %0b got %0b", w.divide_error, got.divide_error); errors++;
      end
      if (got.loss_saturated !== w.loss_saturated) begin
        $error("loss_saturated exp %0b got %0b", w.loss_saturated, got.loss_saturated);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [2:0]         in_channel;
  logic signed [14:0] in_voltage_angle;
  logic signed [14:0] in_current_angle;
  logic [31:0]        in_voltage_magnitude;
  logic [31:0]        in_current_magnitude;
  logic               out_empty;
  logic               out_pop;
  logic [2:0]         out_channel_out;
  logic signed [15:0] out_power_factor;
  logic signed [31:0] out_loss_factor;
  logic signed [32:0] out_resistive_current;
  logic [32:0]        out_capacitive_current;
  logic [31:0]        out_reactance;
  logic               out_divide_error;
  logic               out_loss_saturated;

  phasor_scoreboard phasor_sb = new();
  bit  calm_phase = 0;    // no idling in the final stretch
  int  quiet_cycles = 0;

  bushing_phasor_loss_factor_top #(.CORDIC_ITERATIONS(CORDIC_STEPS)) DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // sample on the edge: note accepted inputs, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full)
        phasor_sb.note_phasor(in_channel, in_voltage_angle, in_current_angle,
                              in_voltage_magnitude, in_current_magnitude);
      if (out_pop && !out_empty)
        phasor_sb.check_result('{out_channel_out, out_power_factor, out_loss_factor,
                                 out_resistive_current, out_capacitive_current,
                                 out_reactance, out_divide_error, out_loss_saturated});
      // watchdog on cycles with no transaction at all
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("tb_bushing_phasor_loss_factor_top: FAIL");
        $finish;
      end
    end
  end

  // receiver: pops in random bursts of stall, none in the last stretch
  initial begin
    int gap;
    out_pop = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        out_pop <= 0;
        repeat (gap) @(posedge clk);
      end else begin
        out_pop <= 1;
        @(posedge clk);
      end
    end
  end

  // present one phasor transaction and hold it until accepted
  task automatic send_phasor(logic [2:0] c, logic signed [14:0] va, logic signed [14:0] ia,
                             logic [31:0] vm, logic [31:0] im);
    if (!calm_phase && $urandom_range(0, 6) == 0) begin
      in_push <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_push              <= 1;
    in_channel           <= c;
    in_voltage_angle     <= va;
    in_current_angle     <= ia;
    in_voltage_magnitude <= vm;
    in_current_magnitude <= im;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  function automatic logic signed [14:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 15'sd11520;
      1: return -15'sd11520;
      2: return 15'($urandom_range(0, 11520));
      default: return 15'(int'($urandom_range(0, 23040)) - 11520);
    endcase
  endfunction

  function automatic logic [31:0] pick_magnitude();
    case ($urandom_range(0, 4))
      0: return 32'hFFFF_FFFF;
      1: return $urandom_range(0, 16);
      2: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic signed [14:0] va;
    rst_n = 0;
    in_push = 0;
    in_channel = 0;
    in_voltage_angle = 0;
    in_current_angle = 0;
    in_voltage_magnitude = 0;
    in_current_magnitude = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: zero, right angles, half turn, angle wrap, extremes of magnitude
    send_phasor(0, 0, 0, 32'h0001_0000, 32'h0001_0000);           // zero sine, ic zero
    send_phasor(1, 15'sd5760, 0, 32'h0001_0000, 32'h0001_0000);   // 90 degrees
    send_phasor(2, -15'sd5760, 0, 32'h0001_0000, 32'h0001_0000);
    send_phasor(3, 15'sd11520, 0, 32'h0001_0000, 32'h0001_0000);  // half turn
    send_phasor(4, 15'sd11520, -15'sd11520, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // full wrap
    send_phasor(5, -15'sd11520, 15'sd11520, 0, 0);
    send_phasor(5, 15'sd5761, 0, 32'hFFFF_FFFF, 1);               // folded, negated
    send_phasor(4, -15'sd5761, 0, 1, 32'hFFFF_FFFF);
    send_phasor(3, 15'sd1, 0, 32'hFFFF_FFFF, 32'h0000_0100);      // huge loss factor
    send_phasor(2, -15'sd1, 0, 32'h0000_0100, 32'h0000_0100);
    send_phasor(1, 15'sd11519, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // near half turn
    send_phasor(0, -15'sd11519, 0, 32'h1234_5678, 32'h8765_4321);
    send_phasor(7, 15'sd2880, -15'sd2880, 32'h7FFF_FFFF, 32'h8000_0000);
    send_phasor(6, 15'sd16383, 15'sh4000, 32'hAAAA_AAAA, 32'h5555_5555);
    send_phasor(1, 15'sd64, 0, 32'hFFFF_FFFF, 32'h0000_0001);     // ic zero, divide error

    // hold the sender until every result is back
    in_push <= 0;
    while (phasor_sb.pending.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - 150) calm_phase = 1;
      va = pick_angle();
      if ($urandom_range(0, 7) == 0)
        send_phasor(3'($urandom_range(0, 7)), va, va + 15'($urandom_range(0, 2)) - 15'sd1,
                    pick_magnitude(), pick_magnitude());
      else
        send_phasor(3'($urandom_range(0, 7)), va, pick_angle(), pick_magnitude(),
                    pick_magnitude());
    end
    in_push <= 0;

    while (phasor_sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (phasor_sb.errors == 0 && phasor_sb.pending.size() == 0)
      $display("tb_bushing_phasor_loss_factor_top: PASS");
    else
      $display("tb_bushing_phasor_loss_factor_top: FAIL");
    $finish;
  end

endmodule
